FILE: design/ccrn_pkg.sv
package ccrn_pkg;

    // Alphabet covered by the membership bitmap.
    localparam int ALPHABET_SIZE = 256;
    localparam int ALPHA_W       = $clog2(ALPHABET_SIZE);
    localparam int CUR_W         = $clog2(ALPHABET_SIZE + 1);
    localparam int BYTE_W        = 8;

    // Command codes.
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Status codes.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_INVERTED = 2'd1;
    localparam logic [1:0] STAT_INVALID  = 2'd2;

    typedef logic [ALPHABET_SIZE-1:0] bitmap_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [BYTE_W-1:0] range_start;
        logic [BYTE_W-1:0] range_end;
    } ccrn_in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              run_valid;
        logic [BYTE_W-1:0] run_start;
        logic [BYTE_W-1:0] run_end;
        logic              more_runs;
        logic              negate_out;
    } ccrn_out_t;

    // Index of the single set bit of a one-hot vector.
    function automatic logic [ALPHA_W-1:0] onehot_index(input bitmap_t oh);
        logic [ALPHA_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < ALPHABET_SIZE; i++) begin
            if (oh[i]) begin
                idx = idx | ALPHA_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: design/char_class_range_normalizer.sv
// Character-class range normalizer.
// Commands arrive on the s_ channel (valid/ready, payload s_data): clear the
// class, add a byte range, or read the next merged run of members. Every
// command gives exactly one result on the m_ channel (valid/ready, m_data)
// with a status, the run found by a read and whether more members follow.
// The negate flag is written on the cfg_ channel and copied into each result.
// A command transfer is held in an input register; the bitmap logic result
// of that command then lands in an output register, which drives m_valid
// and m_data until the result transfers.
// One command is taken per cycle as long as results are taken; the bitmap,
// error mark and read cursor are updated by one pass of logic over the
// 256-bit bitmap per command.
// When the receiver stalls, the result is held and one further command is
// buffered in the input register before s_ready drops.
// Synchronous active-low reset empties the class, clears the error mark,
// the read cursor and the negate flag, and drops both valid registers.
module char_class_range_normalizer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ccrn_pkg::ccrn_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ccrn_pkg::ccrn_out_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);

    logic                in_valid_reg;
    ccrn_pkg::ccrn_in_t  in_data_reg;
    logic                out_valid_reg;
    ccrn_pkg::ccrn_out_t out_data_reg;
    logic                negate_reg;
    logic                out_free;
    logic                step;
    ccrn_pkg::ccrn_out_t result;

    // Handshake: the input stage moves on when the output register has room.
    assign out_free  = !out_valid_reg || m_ready;
    assign step      = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    ccrn_class_state u_class_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_data_reg),
        .negate  (negate_reg),
        .result  (result)
    );

    // Negate register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            negate_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            negate_reg <= cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= result;
        end
    end

endmodule

FILE: design/ccrn_run_find.sv
module ccrn_run_find (
    input  ccrn_pkg::bitmap_t              member_bits,
    input  logic [ccrn_pkg::CUR_W-1:0]     read_cursor,
    output logic                           found,
    output logic [ccrn_pkg::ALPHA_W-1:0]   start_idx,
    output logic [ccrn_pkg::ALPHA_W-1:0]   end_idx,
    output logic                           more
);

    ccrn_pkg::bitmap_t                  below;
    ccrn_pkg::bitmap_t                  live;
    ccrn_pkg::bitmap_t                  low_bit;
    logic [ccrn_pkg::ALPHABET_SIZE:0]   run_sum;
    ccrn_pkg::bitmap_t                  rest;
    ccrn_pkg::bitmap_t                  run;
    ccrn_pkg::bitmap_t                  start_oh;
    ccrn_pkg::bitmap_t                  end_oh;

    // Bits below the cursor have already been returned.
    always_comb begin
        for (int i = 0; i < ccrn_pkg::ALPHABET_SIZE; i++) begin
            below[i] = (i < int'(read_cursor));
        end
    end

    // Adding the lowest set bit ripples through the lowest run and clears it,
    // which leaves the bits that lie beyond that run.
    always_comb begin
        live     = member_bits & ~below;
        low_bit  = live & (~live + 1'b1);
        run_sum  = {1'b0, live} + {1'b0, low_bit};
        rest     = live & run_sum[ccrn_pkg::ALPHABET_SIZE-1:0];
        run      = live & ~rest;
        start_oh = run & ~{run[ccrn_pkg::ALPHABET_SIZE-2:0], 1'b0};
        end_oh   = run & ~{1'b0, run[ccrn_pkg::ALPHABET_SIZE-1:1]};
    end

    assign found     = |live;
    assign more      = |rest;
    assign start_idx = ccrn_pkg::onehot_index(start_oh);
    assign end_idx   = ccrn_pkg::onehot_index(end_oh);

endmodule

FILE: design/ccrn_class_state.sv
module ccrn_class_state (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  ccrn_pkg::ccrn_in_t  item,
    input  logic                negate,
    output ccrn_pkg::ccrn_out_t result
);

    ccrn_pkg::bitmap_t               bits_reg;
    ccrn_pkg::bitmap_t               bits_next;
    logic                            invalid_reg;
    logic                            invalid_next;
    logic [ccrn_pkg::CUR_W-1:0]      cursor_reg;
    logic [ccrn_pkg::CUR_W-1:0]      cursor_next;
    ccrn_pkg::bitmap_t               add_mask;
    logic                            found;
    logic [ccrn_pkg::ALPHA_W-1:0]    start_idx;
    logic [ccrn_pkg::ALPHA_W-1:0]    end_idx;
    logic                            more;

    ccrn_run_find u_run_find (
        .member_bits (bits_reg),
        .read_cursor (cursor_reg),
        .found       (found),
        .start_idx   (start_idx),
        .end_idx     (end_idx),
        .more        (more)
    );

    // Bits covered by the range of an add; values past the alphabet drop out.
    always_comb begin
        for (int i = 0; i < ccrn_pkg::ALPHABET_SIZE; i++) begin
            add_mask[i] = (i >= int'(item.range_start)) && (i <= int'(item.range_end));
        end
    end

    // Command decode: next state and the result of this command.
    always_comb begin
        bits_next         = bits_reg;
        invalid_next      = invalid_reg;
        cursor_next       = cursor_reg;
        result            = '0;
        result.negate_out = negate;
        case (item.cmd)
            ccrn_pkg::CMD_CLEAR: begin
                bits_next    = '0;
                invalid_next = 1'b0;
                cursor_next  = '0;
            end
            ccrn_pkg::CMD_ADD: begin
                cursor_next = '0;
                if (item.range_end < item.range_start) begin
                    invalid_next  = 1'b1;
                    result.status = ccrn_pkg::STAT_INVERTED;
                end else begin
                    bits_next     = bits_reg | add_mask;
                    result.status = invalid_reg ? ccrn_pkg::STAT_INVALID : ccrn_pkg::STAT_OK;
                end
            end
            ccrn_pkg::CMD_READ: begin
                if (invalid_reg) begin
                    result.status = ccrn_pkg::STAT_INVALID;
                end else if (found) begin
                    result.run_valid = 1'b1;
                    result.run_start = ccrn_pkg::BYTE_W'(start_idx);
                    result.run_end   = ccrn_pkg::BYTE_W'(end_idx);
                    result.more_runs = more;
                    cursor_next      = ccrn_pkg::CUR_W'(end_idx) + 1'b1;
                end
            end
            default: begin
                result.status = invalid_reg ? ccrn_pkg::STAT_INVALID : ccrn_pkg::STAT_OK;
            end
        endcase
    end

    // State updates only when a command leaves the input stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg    <= '0;
            invalid_reg <= 1'b0;
            cursor_reg  <= '0;
        end else if (step) begin
            bits_reg    <= bits_next;
            invalid_reg <= invalid_next;
            cursor_reg  <= cursor_next;
        end
    end

endmodule

FILE: tb/char_class_range_normalizer_tb.sv
module char_class_range_normalizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 1000;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    ccrn_pkg::ccrn_in_t  s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    ccrn_pkg::ccrn_out_t m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_data  = 1'b0;

    // Commands waiting to be driven and results predicted but not yet seen.
    ccrn_pkg::ccrn_in_t  pending_cmds[$];
    ccrn_pkg::ccrn_out_t predicted_results[$];

    int issued_cmds   = 0;
    int accepted_cmds = 0;
    int mismatches    = 0;
    int stall_cycles  = 0;
    int idle_pct      = 34;
    bit cmd_taken     = 1'b0;

    // Shadow state of the character class.
    logic [ccrn_pkg::ALPHABET_SIZE-1:0] class_bits    = '0;
    logic                               class_invalid = 1'b0;
    logic [ccrn_pkg::CUR_W-1:0]         class_cursor  = '0;
    logic                               negate_shadow = 1'b0;

    char_class_range_normalizer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Applies one command to the shadow class and returns the result it must give.
    function automatic ccrn_pkg::ccrn_out_t class_command_result(ccrn_pkg::ccrn_in_t c);
        ccrn_pkg::ccrn_out_t r;
        int first;
        int last;
        r = '0;
        r.negate_out = negate_shadow;
        case (c.cmd)
            ccrn_pkg::CMD_CLEAR: begin
                class_bits    = '0;
                class_invalid = 1'b0;
                class_cursor  = '0;
            end
            ccrn_pkg::CMD_ADD: begin
                class_cursor = '0;
                if (c.range_end < c.range_start) begin
                    class_invalid = 1'b1;
                    r.status      = ccrn_pkg::STAT_INVERTED;
                end else begin
                    for (int i = int'(c.range_start);
                         i <= int'(c.range_end) && i < ccrn_pkg::ALPHABET_SIZE; i++)
                        class_bits[i] = 1'b1;
                    r.status = class_invalid ? ccrn_pkg::STAT_INVALID : ccrn_pkg::STAT_OK;
                end
            end
            ccrn_pkg::CMD_READ: begin
                if (class_invalid) begin
                    r.status = ccrn_pkg::STAT_INVALID;
                end else begin
                    // Find the next member at or after the cursor, then the end of its run.
                    first = int'(class_cursor);
                    while (first < ccrn_pkg::ALPHABET_SIZE && !class_bits[first])
                        first++;
                    if (first < ccrn_pkg::ALPHABET_SIZE) begin
                        last = first;
                        while (last + 1 < ccrn_pkg::ALPHABET_SIZE && class_bits[last + 1])
                            last++;
                        r.run_valid = 1'b1;
                        r.run_start = ccrn_pkg::BYTE_W'(first);
                        r.run_end   = ccrn_pkg::BYTE_W'(last);
                        for (int i = last + 1; i < ccrn_pkg::ALPHABET_SIZE; i++)
                            if (class_bits[i])
                                r.more_runs = 1'b1;
                        class_cursor = ccrn_pkg::CUR_W'(last + 1);
                    end
                end
            end
            default: begin
                r.status = class_invalid ? ccrn_pkg::STAT_INVALID : ccrn_pkg::STAT_OK;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
        mismatches++;
    endtask

    // Command driver: a new command is offered once the previous one has transferred; m_ready is also randomized here.
    always @(negedge aclk) begin
        if (aresetn) begin
            m_ready <= ($urandom_range(99) >= idle_pct);
            if (!s_valid || cmd_taken) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    s_data  <= pending_cmds.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            cmd_taken = 1'b0;
        end
    end

    // Monitor: predicts on each command transfer, checks each result transfer,
    // and ends the run if nothing moves for too long.
    always @(posedge aclk) begin
        ccrn_pkg::ccrn_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predicted_results.push_back(class_command_result(s_data));
                accepted_cmds++;
                cmd_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch("unexpected result", int'(m_data), 0);
                end else begin
                    want = predicted_results.pop_front();
                    if (m_data.status !== want.status)
                        report_mismatch("status", int'(m_data.status), int'(want.status));
                    if (m_data.run_valid !== want.run_valid)
                        report_mismatch("run_valid", int'(m_data.run_valid),
                                        int'(want.run_valid));
                    if (m_data.run_start !== want.run_start)
                        report_mismatch("run_start", int'(m_data.run_start),
                                        int'(want.run_start));
                    if (m_data.run_end !== want.run_end)
                        report_mismatch("run_end", int'(m_data.run_end), int'(want.run_end));
                    if (m_data.more_runs !== want.more_runs)
                        report_mismatch("more_runs", int'(m_data.more_runs),
                                        int'(want.more_runs));
                    if (m_data.negate_out !== want.negate_out)
                        report_mismatch("negate_out", int'(m_data.negate_out),
                                        int'(want.negate_out));
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic queue_cmd(logic [1:0] cmd, int lo, int hi);
        ccrn_pkg::ccrn_in_t c;
        c.cmd         = cmd;
        c.range_start = ccrn_pkg::BYTE_W'(lo);
        c.range_end   = ccrn_pkg::BYTE_W'(hi);
        pending_cmds.push_back(c);
        issued_cmds++;
    endtask

    // Waits until every command has transferred and every result has been checked.
    task automatic drain();
        do
            @(negedge aclk);
        while (accepted_cmds != issued_cmds || predicted_results.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    // Writes the negate flag; only called while the block is idle.
    task automatic write_negate(logic value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge aclk);
        while (!cfg_ready);
        negate_shadow = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
        cfg_data  = 1'($urandom_range(1));
    endtask

    // One class session: usually a clear, a few adds, then reads walking the runs.
    task automatic queue_session();
        int n_adds;
        int n_reads;
        int lo;
        int hi;
        int pick;
        if ($urandom_range(9) != 0)
            queue_cmd(ccrn_pkg::CMD_CLEAR, $urandom_range(255), $urandom_range(255));
        n_adds = $urandom_range(1, 5);
        for (int k = 0; k < n_adds; k++) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                lo = $urandom_range(1, 255);
                queue_cmd(ccrn_pkg::CMD_ADD, lo, $urandom_range(lo - 1));
            end else if (pick < 16) begin
                queue_cmd(ccrn_pkg::CMD_ADD, $urandom_range(255), $urandom_range(255));
            end else if (pick < 20) begin
                queue_cmd(ccrn_pkg::CMD_UNUSED, $urandom_range(255), $urandom_range(255));
            end else begin
                lo = $urandom_range(255);
                hi = lo + $urandom_range(12);
                queue_cmd(ccrn_pkg::CMD_ADD, lo, (hi > 255) ? 255 : hi);
            end
        end
        n_reads = $urandom_range(1, n_adds + 2);
        for (int k = 0; k < n_reads; k++)
            queue_cmd(ccrn_pkg::CMD_READ, $urandom_range(255), $urandom_range(255));
        // Sometimes add mid-walk so the cursor restarts.
        if ($urandom_range(4) == 0) begin
            lo = $urandom_range(255);
            queue_cmd(ccrn_pkg::CMD_ADD, lo, lo);
            queue_cmd(ccrn_pkg::CMD_READ, 0, 0);
            queue_cmd(ccrn_pkg::CMD_READ, 255, 255);
        end
    endtask

    task automatic run_random_phase(int count);
        int goal;
        goal = issued_cmds + count;
        while (issued_cmds < goal)
            queue_session();
        drain();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: merging, cursor behavior, errors and the unused command.
        write_negate(1'b1);
        queue_cmd(ccrn_pkg::CMD_CLEAR, 0, 0);
        queue_cmd(ccrn_pkg::CMD_READ, 0, 0);
        queue_cmd(ccrn_pkg::CMD_ADD, 10, 20);
        queue_cmd(ccrn_pkg::CMD_ADD, 21, 30);
        queue_cmd(ccrn_pkg::CMD_ADD, 25, 40);
        queue_cmd(ccrn_pkg::CMD_ADD, 50, 50);
        queue_cmd(ccrn_pkg::CMD_ADD, 255, 255);
        queue_cmd(ccrn_pkg::CMD_READ, 0, 0);
        queue_cmd(ccrn_pkg::CMD_READ, 0, 0);
        queue_cmd(ccrn_pkg::CMD_READ, 0, 0);
        queue_cmd(ccrn_pkg::CMD_READ, 0, 0);
        queue_cmd(ccrn_pkg::CMD_ADD, 0, 0);
        queue_cmd(ccrn_pkg::CMD_READ, 255, 255);
        queue_cmd(ccrn_pkg::CMD_UNUSED, 255, 0);
        queue_cmd(ccrn_pkg::CMD_ADD, 255, 0);
        queue_cmd(ccrn_pkg::CMD_ADD, 60, 70);
        queue_cmd(ccrn_pkg::CMD_READ, 0, 0);
        queue_cmd(ccrn_pkg::CMD_UNUSED, 0, 255);
        queue_cmd(ccrn_pkg::CMD_CLEAR, 255, 255);
        queue_cmd(ccrn_pkg::CMD_ADD, 0, 255);
        queue_cmd(ccrn_pkg::CMD_READ, 0, 0);
        queue_cmd(ccrn_pkg::CMD_READ, 0, 0);
        queue_cmd(ccrn_pkg::CMD_CLEAR, 0, 0);
        queue_cmd(ccrn_pkg::CMD_ADD, 128, 127);
        queue_cmd(ccrn_pkg::CMD_READ, 0, 0);
        drain();

        // Random sessions under several settings, one stretch without idling.
        write_negate(1'b0);
        run_random_phase(500);
        write_negate(1'b1);
        idle_pct = 0;
        run_random_phase(350);
        idle_pct = 34;
        write_negate(1'($urandom_range(1)));
        run_random_phase(650);

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: files.f
design/ccrn_pkg.sv
design/ccrn_run_find.sv
design/ccrn_class_state.sv
design/char_class_range_normalizer.sv
tb/char_class_range_normalizer_tb.sv
